@@ hw/rtl/spd_pkg.sv @@
// ----------------------------------------------------------------------------
// Signal pending dispatch package
// Shared types, codes and sizes for the signal pending dispatch block.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int PROCESS_SLOTS = 8;
  localparam int SIGNAL_COUNT  = 32;

  localparam int PROC_W   = 3;
  localparam int SIGNUM_W = 6;
  localparam int DSIG_W   = 5;
  localparam int ACTIVE_W = 4;
  localparam int WORD_W   = 64;
  localparam int CODE_W   = 8;
  localparam int MASK_W   = SIGNAL_COUNT - 1;
  localparam int SIGIDX_W = $clog2(SIGNAL_COUNT);
  localparam int ADDR_W   = PROC_W + SIGIDX_W;
  localparam int RAM_DEPTH = PROCESS_SLOTS * SIGNAL_COUNT;

  localparam logic [1:0] OP_INSTALL = 2'd0;
  localparam logic [1:0] OP_SEND    = 2'd1;
  localparam logic [1:0] OP_DELIVER = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ENTER = 2'd1;
  localparam logic [1:0] ACT_EXIT  = 2'd2;

  localparam int SIG_INT  = 2;
  localparam int SIG_KILL = 9;
  localparam int SIG_TERM = 15;

  localparam logic [CODE_W-1:0] EXIT_BASE  = 8'd128;
  localparam logic [WORD_W-1:0] FRAME_WORD = 64'd8;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic [MASK_W-1:0] FATAL_MASK =
    (MASK_W'(1) << (SIG_INT - 1)) | (MASK_W'(1) << (SIG_KILL - 1)) |
    (MASK_W'(1) << (SIG_TERM - 1));

  typedef struct packed {
    logic [1:0]          opcode;
    logic [PROC_W-1:0]   process;
    logic [SIGNUM_W-1:0] signal_number;
    logic [WORD_W-1:0]   handler_address;
    logic [WORD_W-1:0]   return_address;
    logic [WORD_W-1:0]   stack_pointer;
  } cmd_t;

  typedef struct packed {
    logic                status;
    logic [1:0]          action;
    logic [DSIG_W-1:0]   delivered_signal;
    logic [WORD_W-1:0]   next_address;
    logic [WORD_W-1:0]   new_stack_pointer;
    logic [WORD_W-1:0]   stack_store_word;
    logic [CODE_W-1:0]   exit_code;
  } result_t;

  typedef struct packed {
    logic              status;
    logic [1:0]        action;
    logic [DSIG_W-1:0] dsig;
  } decision_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ hw/rtl/spd_handler_ram.sv @@
// ----------------------------------------------------------------------------
// Handler address memory
// One handler address per process and signal, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module spd_handler_ram (
  input  logic                                clk,
  input  logic                                we,
  input  logic [spd_pkg::ADDR_W-1:0]          waddr,
  input  logic [spd_pkg::WORD_W-1:0]          wdata,
  input  logic [spd_pkg::ADDR_W-1:0]          raddr,
  output logic [spd_pkg::WORD_W-1:0]          rdata
);
  import spd_pkg::*;

  logic [WORD_W-1:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/spd_pending.sv @@
// ----------------------------------------------------------------------------
// Pending mask and handler presence tracking
// Holds the pending mask and handler presence flags of every process, picks
// the signal to deliver and drives the handler memory.
// ----------------------------------------------------------------------------
module spd_pending (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              valid,
  input  spd_pkg::cmd_t                     cmd,
  input  logic [spd_pkg::ACTIVE_W-1:0]      active_processes,
  output spd_pkg::decision_t                decision,
  output spd_pkg::ram_req_t                 ram_req
);
  import spd_pkg::*;

  logic [PROCESS_SLOTS-1:0][MASK_W-1:0] pending;
  logic [PROCESS_SLOTS-1:0][MASK_W-1:0] handler_set;

  logic [PROC_W-1:0]   proc;
  logic                sig_ok;
  logic [DSIG_W-1:0]   sig_idx;
  logic [MASK_W-1:0]   cur;
  logic [MASK_W-1:0]   set;
  logic [MASK_W-1:0]   cands;
  logic [MASK_W-1:0]   low;
  logic [MASK_W-1:0]   clr;
  logic [DSIG_W-1:0]   pick;
  logic                found;
  logic                enter;
  logic                send_bad;

  always_comb begin
    proc     = cmd.process;
    sig_ok   = (cmd.signal_number != '0) &&
               (cmd.signal_number < SIGNUM_W'(SIGNAL_COUNT));
    sig_idx  = DSIG_W'(cmd.signal_number - SIGNUM_W'(1));
    cur      = pending[proc];
    set      = handler_set[proc];
    cands    = cur & (set | FATAL_MASK);
    low      = cands & (~cands + MASK_W'(1));
    clr      = low | (low - MASK_W'(1));
    found    = |cands;
    enter    = |(low & set);
    send_bad = {1'b0, proc} >= active_processes;
    pick     = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (low[i]) begin
        pick = pick | DSIG_W'(i + 1);
      end
    end
  end

  always_comb begin
    decision = '0;
    ram_req.we    = 1'b0;
    ram_req.waddr = {proc, cmd.signal_number[SIGIDX_W-1:0]};
    ram_req.raddr = {proc, pick[SIGIDX_W-1:0]};
    case (cmd.opcode)
      OP_INSTALL: begin
        decision.status = !sig_ok;
        ram_req.we      = valid && sig_ok;
      end
      OP_SEND: begin
        decision.status = !sig_ok || send_bad;
      end
      OP_DELIVER: begin
        if (found) begin
          decision.action = enter ? ACT_ENTER : ACT_EXIT;
          decision.dsig   = pick;
        end
      end
      default: begin
        decision.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      handler_set <= '0;
    end else if (valid) begin
      case (cmd.opcode)
        OP_INSTALL: begin
          if (sig_ok) begin
            handler_set[proc][sig_idx] <= (cmd.handler_address != '0);
          end
        end
        OP_SEND: begin
          if (sig_ok && !send_bad) begin
            pending[proc][sig_idx] <= 1'b1;
          end
        end
        OP_DELIVER: begin
          pending[proc] <= cur & ~clr;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/signal_pending_dispatch_core.sv @@
// ----------------------------------------------------------------------------
// Signal pending dispatch core
// Per-process pending signal masks and handler tables with install, send and
// deliver commands.
// ----------------------------------------------------------------------------
// A command is transferred at a rising edge with start high and busy low.
// The command register takes it; the pending masks, handler flags and
// handler memory are updated at the same edge that loads the result
// registers, and the result is shown on result with result_valid high
// for exactly one cycle.
// busy never rises, so a new command can be transferred every cycle and one
// result leaves every cycle. Each command sees all state changes made by the
// commands before it.
// The number of live processes is written through cfg_write and cfg_data;
// the user must only write it with no command in flight; not enforced.
// Synchronous reset clears all pending masks and handler flags, sets the
// live process count to eight and drops any command in flight. Handler
// entries read as the default action until written after reset.
// The receiver cannot stall: each result must be taken in its one cycle.
// ----------------------------------------------------------------------------
module signal_pending_dispatch_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  spd_pkg::cmd_t                 command,
  input  logic                          cfg_write,
  input  logic [spd_pkg::ACTIVE_W-1:0]  cfg_data,
  output logic                          result_valid,
  output spd_pkg::result_t              result
);
  import spd_pkg::*;

  logic                cmd_valid;
  cmd_t                cmd;
  logic [ACTIVE_W-1:0] active_processes;
  decision_t           decision;
  ram_req_t            ram_req;
  logic [WORD_W-1:0]   ram_rdata;

  logic                res_valid;
  logic                res_status;
  logic [1:0]          res_action;
  logic [DSIG_W-1:0]   res_dsig;
  logic [WORD_W-1:0]   res_nsp;
  logic [WORD_W-1:0]   res_store;
  logic [CODE_W-1:0]   res_code;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_processes <= ACTIVE_RESET;
    end else if (cfg_write) begin
      active_processes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
    if (start && !busy) begin
      cmd <= command;
    end
  end

  spd_pending u_pending (
    .clk              (clk),
    .rst              (rst),
    .valid            (cmd_valid),
    .cmd              (cmd),
    .active_processes (active_processes),
    .decision         (decision),
    .ram_req          (ram_req)
  );

  spd_handler_ram u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (cmd.handler_address),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cmd_valid;
    end
    res_status <= decision.status;
    res_action <= decision.action;
    res_dsig   <= decision.dsig;
    res_nsp    <= (decision.action == ACT_ENTER) ? cmd.stack_pointer - FRAME_WORD
                                                 : cmd.stack_pointer;
    res_store  <= (decision.action == ACT_ENTER) ? cmd.return_address : '0;
    res_code   <= (decision.action == ACT_EXIT) ? EXIT_BASE + CODE_W'(decision.dsig)
                                                : '0;
  end

  assign result_valid = res_valid;

  always_comb begin
    result.status            = res_status;
    result.action            = res_action;
    result.delivered_signal  = res_dsig;
    result.next_address      = (res_action == ACT_ENTER) ? ram_rdata : '0;
    result.new_stack_pointer = res_nsp;
    result.stack_store_word  = res_store;
    result.exit_code         = res_code;
  end

endmodule
